[sv/slcr_pkg.sv]
package slcr_pkg;

   // fixed field widths
   localparam int KIND_W        = 2;
   localparam int SPRITE_W      = 4;
   localparam int XPOS_W        = 16;
   localparam int ROW_BITS_W    = 32;
   localparam int ROW_WIDTH_W   = 6;
   localparam int COLOUR_W      = 24;
   localparam int MASK_W        = 8;
   localparam int COLUMN_W      = 9;
   localparam int OWNER_W       = SPRITE_W + 1;
   localparam int SPRITE_NUM    = 1 << SPRITE_W;
   localparam int BITPOS_W      = 5;

   // stream packing
   localparam int REQ_TDATA_W   = 96;
   localparam int REQ_TUSER_W   = KIND_W;
   localparam int RSP_TDATA_W   = 48;
   localparam int RSP_TUSER_W   = 1;

   // parameter defaults
   localparam int LINE_WIDTH_DEFAULT   = 320;
   localparam int SPRITE_COUNT_DEFAULT = 16;
   localparam int MAX_ROW_BITS_DEFAULT = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_LINE_START  = 2'd0,
      KIND_SPRITE_ROW  = 2'd1,
      KIND_FRAME_START = 2'd2,
      KIND_READ        = 2'd3
   } req_kind_type;

   localparam logic RPT_PIXEL     = 1'b0;
   localparam logic RPT_COLLISION = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_REPORT
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic store_mask;
      logic frame_clear;
      logic clear_start;
      logic clear_step;
      logic scan;
      logic flush;
      logic report;
   } dp_cmd_type;

   typedef struct packed {
      logic req_in_range;
      logic clear_done;
      logic scan_done;
      logic pend_valid;
      logic out_free;
   } dp_status_type;

endpackage

[sv/slcr_ctrl.sv]
module slcr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  slcr_pkg::req_kind_type     req_kind,
   input  slcr_pkg::dp_status_type    status,
   output slcr_pkg::dp_cmd_type       cmd
);
   import slcr_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = accept;
            if (accept) begin
               unique case (req_kind)
                  KIND_LINE_START: begin
                     cmd.clear_start = 1'b1;
                     state_in        = ST_CLEAR;
                  end
                  KIND_SPRITE_ROW: begin
                     if (status.req_in_range) begin
                        cmd.store_mask = 1'b1;
                        state_in       = ST_SCAN;
                     end
                  end
                  KIND_FRAME_START: begin
                     cmd.frame_clear = 1'b1;
                  end
                  KIND_READ: begin
                     state_in = ST_REPORT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (status.out_free) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[sv/slcr_datapath.sv]
module slcr_datapath #(
   parameter int LINE_WIDTH   = slcr_pkg::LINE_WIDTH_DEFAULT,
   parameter int SPRITE_COUNT = slcr_pkg::SPRITE_COUNT_DEFAULT,
   parameter int MAX_ROW_BITS = slcr_pkg::MAX_ROW_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  slcr_pkg::dp_cmd_type               cmd,
   output slcr_pkg::dp_status_type            status,
   input  logic [slcr_pkg::SPRITE_W-1:0]      req_sprite_index,
   input  logic signed [slcr_pkg::XPOS_W-1:0] req_x_position,
   input  logic [slcr_pkg::ROW_BITS_W-1:0]    req_row_bits,
   input  logic [slcr_pkg::ROW_WIDTH_W-1:0]   req_row_width,
   input  logic [slcr_pkg::COLOUR_W-1:0]      req_pixel_colour,
   input  logic [slcr_pkg::MASK_W-1:0]        req_collision_mask,
   input  logic                               rsp_tready,
   output logic                               rsp_valid,
   output logic                               rsp_report_kind,
   output logic [slcr_pkg::COLUMN_W-1:0]      rsp_column,
   output logic [slcr_pkg::COLOUR_W-1:0]      rsp_colour_out,
   output logic [slcr_pkg::MASK_W-1:0]        rsp_collision_bits,
   output logic                               rsp_last
);
   import slcr_pkg::*;

   localparam int COL_W  = $clog2(LINE_WIDTH);
   localparam int SLOTS  = (SPRITE_COUNT < SPRITE_NUM) ? SPRITE_COUNT : SPRITE_NUM;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // latched request
   logic [SPRITE_W-1:0]      sprite_ff;
   logic                     in_range_ff;
   logic signed [XPOS_W-1:0] xpos_ff;
   logic [ROW_BITS_W-1:0]    bits_ff;
   logic [ROW_WIDTH_W-1:0]   width_ff;
   logic [COLOUR_W-1:0]      colour_ff;
   logic [MASK_W-1:0]        mask_ff;
   logic [ROW_WIDTH_W-1:0]   width_clamped;
   logic                     req_in_range;

   // per-sprite state
   logic [MASK_W-1:0] masks_ff [SLOTS];
   logic [MASK_W-1:0] accum_ff [SLOTS];
   logic [MASK_W-1:0] accum_in [SLOTS];

   // column owner store
   logic [OWNER_W-1:0] owner_mem [LINE_WIDTH];
   logic [OWNER_W-1:0] owner_rd_ff;
   logic               mem_we;
   logic [COL_W-1:0]   mem_wa;
   logic [OWNER_W-1:0] mem_wd;
   logic [COL_W-1:0]   clear_addr_ff;

   // scan stage
   logic [ROW_WIDTH_W-1:0]  idx_ff;
   logic                    a_active;
   logic [BITPOS_W-1:0]     bitpos;
   logic signed [XPOS_W:0]  col_s;
   logic                    a_hit;

   // check stage
   logic                b_valid_ff;
   logic [COL_W-1:0]    b_addr_ff;
   logic [COLUMN_W-1:0] b_column_ff;
   logic                b_free;
   logic                claim;
   logic                owned;
   logic [SPRITE_W-1:0] other;
   logic                other_in;
   logic [MASK_W-1:0]   other_mask;
   logic                stall;
   logic                adv;

   // pending pixel, held until the next one shows whether it is last
   logic                pend_valid_ff;
   logic [COLUMN_W-1:0] pend_column_ff;

   // output register
   logic                out_valid_ff;
   logic                out_kind_ff;
   logic [COLUMN_W-1:0] out_column_ff;
   logic [COLOUR_W-1:0] out_colour_ff;
   logic [MASK_W-1:0]   out_bits_ff;
   logic                out_last_ff;
   logic                out_free;
   logic                push_pend;

   assign req_in_range  = 32'(req_sprite_index) < SPRITE_COUNT;
   assign width_clamped = (32'(req_row_width) > MAX_ROW_BITS) ?
                          ROW_WIDTH_W'(MAX_ROW_BITS) : req_row_width;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sprite_ff   <= req_sprite_index;
         in_range_ff <= req_in_range;
         xpos_ff     <= req_x_position;
         bits_ff     <= req_row_bits;
         colour_ff   <= req_pixel_colour;
         mask_ff     <= req_collision_mask;
      end
      if (cmd.store_mask) begin
         masks_ff[req_sprite_index[SLOT_W-1:0]] <= req_collision_mask;
      end
   end

   // scan stage: one bitmap bit per advance, leftmost first
   assign a_active = idx_ff != width_ff;
   assign bitpos   = BITPOS_W'(width_ff - ROW_WIDTH_W'(1) - idx_ff);
   assign col_s    = {xpos_ff[XPOS_W-1], xpos_ff} +
                     (XPOS_W+1)'(signed'({1'b0, idx_ff}));
   assign a_hit    = a_active && bits_ff[bitpos] && !col_s[XPOS_W] &&
                     (col_s[XPOS_W-1:0] < XPOS_W'(LINE_WIDTH));

   // check stage
   assign b_free     = owner_rd_ff == '0;
   assign claim      = b_valid_ff && b_free;
   assign owned      = b_valid_ff && !b_free;
   assign other      = SPRITE_W'(owner_rd_ff - OWNER_W'(1));
   assign other_in   = 32'(other) < SPRITE_COUNT;
   assign other_mask = other_in ? masks_ff[other[SLOT_W-1:0]] : '0;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign stall     = claim && pend_valid_ff && !out_free;
   assign adv       = cmd.scan && !stall;
   assign push_pend = adv && claim && pend_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         width_ff      <= '0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         clear_addr_ff <= '0;
      end else begin
         if (cmd.store_mask) begin
            idx_ff     <= '0;
            width_ff   <= width_clamped;
            b_valid_ff <= 1'b0;
         end else if (adv) begin
            if (a_active) begin
               idx_ff <= idx_ff + ROW_WIDTH_W'(1);
            end
            b_valid_ff <= a_hit;
         end
         if (adv && claim) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.clear_start) begin
            clear_addr_ff <= '0;
         end else if (cmd.clear_step) begin
            clear_addr_ff <= clear_addr_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_addr_ff   <= col_s[COL_W-1:0];
         b_column_ff <= col_s[COLUMN_W-1:0];
      end
      if (adv && claim) begin
         pend_column_ff <= b_column_ff;
      end
   end

   // owner store, one write and one registered read per cycle
   assign mem_we = cmd.clear_step || (adv && claim);
   assign mem_wa = cmd.clear_step ? clear_addr_ff : b_addr_ff;
   assign mem_wd = cmd.clear_step ? '0 : OWNER_W'(sprite_ff) + OWNER_W'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         owner_mem[mem_wa] <= mem_wd;
      end
      if (adv) begin
         owner_rd_ff <= owner_mem[col_s[COL_W-1:0]];
      end
   end

   // collision accumulators
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         accum_in[k] = accum_ff[k];
         if (cmd.frame_clear) begin
            accum_in[k] = '0;
         end else if (adv && owned && other_in) begin
            if (other[SLOT_W-1:0] == SLOT_W'(k)) begin
               accum_in[k] = accum_in[k] | mask_ff;
            end
            if (sprite_ff[SLOT_W-1:0] == SLOT_W'(k)) begin
               accum_in[k] = accum_in[k] | other_mask;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLOTS; k++) begin
         if (reset) begin
            accum_ff[k] <= '0;
         end else begin
            accum_ff[k] <= accum_in[k];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (push_pend || cmd.flush || cmd.report) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push_pend || cmd.flush) begin
         out_kind_ff   <= RPT_PIXEL;
         out_column_ff <= pend_column_ff;
         out_colour_ff <= colour_ff;
         out_bits_ff   <= '0;
         out_last_ff   <= cmd.flush;
      end else if (cmd.report) begin
         out_kind_ff   <= RPT_COLLISION;
         out_column_ff <= '0;
         out_colour_ff <= '0;
         out_bits_ff   <= in_range_ff ? accum_ff[sprite_ff[SLOT_W-1:0]] : '0;
         out_last_ff   <= 1'b1;
      end
   end

   assign status.req_in_range = req_in_range;
   assign status.clear_done   = clear_addr_ff == COL_W'(LINE_WIDTH - 1);
   assign status.scan_done    = !a_active && !b_valid_ff;
   assign status.pend_valid   = pend_valid_ff;
   assign status.out_free     = out_free;

   assign rsp_valid          = out_valid_ff;
   assign rsp_report_kind    = out_kind_ff;
   assign rsp_column         = out_column_ff;
   assign rsp_colour_out     = out_colour_ff;
   assign rsp_collision_bits = out_bits_ff;
   assign rsp_last           = out_last_ff;

endmodule

[sv/sprite_line_collision_renderer.sv]
// a sprite row is scanned over its clamped width through the scan and check stages,
//   holding while the result side stalls; a read is reported once the output is free
// throughput: one bitmap bit per cycle unless the result side stalls
// line start walks the owner store one column a cycle, clearing every column
// reset: synchronous, active high; afterwards a clearing pass of the owner store runs
//   with req_tready low
module sprite_line_collision_renderer #(
   parameter int LINE_WIDTH   = slcr_pkg::LINE_WIDTH_DEFAULT,
   parameter int SPRITE_COUNT = slcr_pkg::SPRITE_COUNT_DEFAULT,
   parameter int MAX_ROW_BITS = slcr_pkg::MAX_ROW_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // sprite_index, x_position, row_bits, row_width, pixel_colour, collision_mask
   input  logic [slcr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind
   input  logic [slcr_pkg::REQ_TUSER_W-1:0]    req_tuser,
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // column, colour_out, collision_bits
   output logic [slcr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // report_kind
   output logic [slcr_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast
);
   import slcr_pkg::*;

   dp_cmd_type               cmd;
   dp_status_type            status;
   req_kind_type             req_kind;

   // unpacked request fields
   logic [SPRITE_W-1:0]      req_sprite_index;
   logic signed [XPOS_W-1:0] req_x_position;
   logic [ROW_BITS_W-1:0]    req_row_bits;
   logic [ROW_WIDTH_W-1:0]   req_row_width;
   logic [COLOUR_W-1:0]      req_pixel_colour;
   logic [MASK_W-1:0]        req_collision_mask;

   // result fields
   logic                     rsp_report_kind;
   logic [COLUMN_W-1:0]      rsp_column;
   logic [COLOUR_W-1:0]      rsp_colour_out;
   logic [MASK_W-1:0]        rsp_collision_bits;

   assign req_kind           = req_kind_type'(req_tuser);
   assign req_sprite_index   = req_tdata[3:0];
   assign req_x_position     = signed'(req_tdata[19:4]);
   assign req_row_bits       = req_tdata[51:20];
   assign req_row_width      = req_tdata[57:52];
   assign req_pixel_colour   = req_tdata[81:58];
   assign req_collision_mask = req_tdata[89:82];

   // sequencer: clearing pass, row scan, flush of the final pixel, report
   slcr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_kind),
      .status     (status),
      .cmd        (cmd)
   );

   // owner store, two-stage bit scan, accumulators and output register
   slcr_datapath #(
      .LINE_WIDTH   (LINE_WIDTH),
      .SPRITE_COUNT (SPRITE_COUNT),
      .MAX_ROW_BITS (MAX_ROW_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_sprite_index   (req_sprite_index),
      .req_x_position     (req_x_position),
      .req_row_bits       (req_row_bits),
      .req_row_width      (req_row_width),
      .req_pixel_colour   (req_pixel_colour),
      .req_collision_mask (req_collision_mask),
      .rsp_tready         (rsp_tready),
      .rsp_valid          (rsp_tvalid),
      .rsp_report_kind    (rsp_report_kind),
      .rsp_column         (rsp_column),
      .rsp_colour_out     (rsp_colour_out),
      .rsp_collision_bits (rsp_collision_bits),
      .rsp_last           (rsp_tlast)
   );

   // pack results, zero fill to whole bytes
   assign rsp_tdata = {7'd0, rsp_collision_bits, rsp_colour_out, rsp_column};
   assign rsp_tuser = rsp_report_kind;

endmodule

[sv/slcr_checker.sv]
module slcr_props (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [slcr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic [slcr_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [slcr_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [slcr_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                              rsp_tlast
);
   import slcr_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a collision report is always the single, final result of its request
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == RPT_COLLISION |-> rsp_tlast)
      else $error("collision report without tlast");

   // a collision report carries no column or colour
   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == RPT_COLLISION |-> rsp_tdata[32:0] == '0)
      else $error("collision report with pixel data");

   // owner store clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during clearing pass");

endmodule

bind sprite_line_collision_renderer slcr_props u_slcr_props (.*);

[bench/slcr_checker.sv]
module slcr_checker #(
   parameter int LINE_WIDTH   = slcr_pkg::LINE_WIDTH_DEFAULT,
   parameter int SPRITE_COUNT = slcr_pkg::SPRITE_COUNT_DEFAULT,
   parameter int MAX_ROW_BITS = slcr_pkg::MAX_ROW_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [slcr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [slcr_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [slcr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [slcr_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                             rsp_tlast,
   output int                               mismatch_total,
   output int                               owed_count,
   output int                               pixel_total,
   output int                               report_total
);

   timeunit 1ns;
   timeprecision 1ps;

   import slcr_pkg::*;

   typedef struct {
      logic                report_kind;
      logic [COLUMN_W-1:0] column;
      logic [COLOUR_W-1:0] colour;
      logic [MASK_W-1:0]   hit_bits;
      logic                is_last;
   } scan_result_type;

   scan_result_type     scan_results_q[$];
   logic [OWNER_W-1:0]  column_owner_m [LINE_WIDTH];
   logic [MASK_W-1:0]   hit_accum      [SPRITE_COUNT];
   logic [MASK_W-1:0]   sprite_mask    [SPRITE_COUNT];
   int                  fail_cnt;
   int                  pixel_cnt;
   int                  report_cnt;

   task automatic flag_mismatch(input string msg);
      fail_cnt++;
      // keep the log short when the block is badly broken
      if (fail_cnt <= 100)
         $display("mismatch at %0t ns: %s", $time, msg);
   endtask

   // renders one accepted request into the expected output stream
   task automatic composite_request(input req_kind_type kind,
                                    input logic [REQ_TDATA_W-1:0] data);
      logic [SPRITE_W-1:0]    spr;
      logic signed [XPOS_W-1:0] xpos;
      logic [ROW_BITS_W-1:0]  bits;
      logic [ROW_WIDTH_W-1:0] w;
      logic [COLOUR_W-1:0]    colour;
      logic [MASK_W-1:0]      mask;
      int                     width;
      int                     col;
      int                     other;
      int                     first_idx;
      scan_result_type        r;
      spr    = data[3:0];
      xpos   = data[19:4];
      bits   = data[51:20];
      w      = data[57:52];
      colour = data[81:58];
      mask   = data[89:82];
      case (kind)
         KIND_LINE_START: begin
            foreach (column_owner_m[c]) column_owner_m[c] = '0;
         end
         KIND_FRAME_START: begin
            foreach (hit_accum[s]) hit_accum[s] = '0;
         end
         KIND_SPRITE_ROW: begin
            if (int'(spr) < SPRITE_COUNT) begin
               sprite_mask[spr] = mask;
               width = (int'(w) > MAX_ROW_BITS) ? MAX_ROW_BITS : int'(w);
               first_idx = scan_results_q.size();
               for (int i = 0; i < width; i++) begin
                  col = int'(xpos) + i;
                  if (bits[width - 1 - i] && col >= 0 && col < LINE_WIDTH) begin
                     if (column_owner_m[col] != '0) begin
                        other = int'(column_owner_m[col]) - 1;
                        if (other < SPRITE_COUNT) begin
                           hit_accum[other] |= sprite_mask[spr];
                           hit_accum[spr]   |= sprite_mask[other];
                        end
                     end else begin
                        column_owner_m[col] = OWNER_W'(spr) + 1'b1;
                        r.report_kind = RPT_PIXEL;
                        r.column      = COLUMN_W'(col);
                        r.colour      = colour;
                        r.hit_bits    = '0;
                        r.is_last     = 1'b0;
                        scan_results_q.push_back(r);
                     end
                  end
               end
               if (scan_results_q.size() > first_idx)
                  scan_results_q[scan_results_q.size() - 1].is_last = 1'b1;
            end
         end
         default: begin
            r.report_kind = RPT_COLLISION;
            r.column      = '0;
            r.colour      = '0;
            r.hit_bits    = (int'(spr) < SPRITE_COUNT) ? hit_accum[spr] : '0;
            r.is_last     = 1'b1;
            scan_results_q.push_back(r);
         end
      endcase
   endtask

   task automatic compare_result();
      scan_result_type want;
      logic [COLUMN_W-1:0] got_col;
      logic [COLOUR_W-1:0] got_colour;
      logic [MASK_W-1:0]   got_bits;
      got_col    = rsp_tdata[8:0];
      got_colour = rsp_tdata[32:9];
      got_bits   = rsp_tdata[40:33];
      if (scan_results_q.size() == 0) begin
         flag_mismatch($sformatf("unexpected result kind %0b col %0d", rsp_tuser, got_col));
      end else begin
         want = scan_results_q.pop_front();
         if (want.report_kind == RPT_PIXEL) pixel_cnt++;
         else report_cnt++;
         if (rsp_tuser[0] !== want.report_kind)
            flag_mismatch($sformatf("report kind %b, want %b", rsp_tuser, want.report_kind));
         if (got_col !== want.column)
            flag_mismatch($sformatf("column %0d, want %0d", got_col, want.column));
         if (got_colour !== want.colour)
            flag_mismatch($sformatf("colour %h, want %h", got_colour, want.colour));
         if (got_bits !== want.hit_bits)
            flag_mismatch($sformatf("collision bits %h, want %h", got_bits, want.hit_bits));
         if (rsp_tlast !== want.is_last)
            flag_mismatch($sformatf("tlast %b, want %b (col %0d)", rsp_tlast, want.is_last,
                                    want.column));
      end
   endtask

   initial begin
      fail_cnt   = 0;
      pixel_cnt  = 0;
      report_cnt = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         scan_results_q.delete();
         foreach (column_owner_m[c]) column_owner_m[c] = '0;
         foreach (hit_accum[s]) hit_accum[s] = '0;
         foreach (sprite_mask[s]) sprite_mask[s] = '0;
      end else begin
         // a result never leaves in the same cycle its request is taken
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            composite_request(req_kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
            compare_result();
      end
      mismatch_total <= fail_cnt;
      owed_count     <= scan_results_q.size();
      pixel_total    <= pixel_cnt;
      report_total   <= report_cnt;
   end

endmodule

[bench/testbench.sv]
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import slcr_pkg::*;

   // cycles with no request or result taken before giving up; covers the
   // post-reset clearing pass, a line start walk and long result stalls
   localparam int QUIET_LIMIT = 4000;
   // settle time at the end, longer than a line start walk
   localparam int DRAIN_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // sprite_index, x_position, row_bits, row_width, pixel_colour, collision_mask
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // kind
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // column, colour_out, collision_bits
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   // report_kind
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   int mismatch_total;
   int owed_count;
   int pixel_total;
   int report_total;
   int sent_total = 0;
   int quiet_cycles = 0;
   // percent chance per cycle of a sender gap and of a receiver stall
   int idle_pct = 0;
   int stall_pct = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   sprite_line_collision_renderer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   slcr_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_total (mismatch_total),
      .owed_count     (owed_count),
      .pixel_total    (pixel_total),
      .report_total   (report_total)
   );

   // result side back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog: any request or result taken resets the quiet count
   always @(posedge clock) begin
      if ((req_tvalid === 1'b1 && req_tready === 1'b1) ||
          (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // one request: random gaps first, then hold until taken; starts and ends at a falling edge
   task automatic send_request(input req_kind_type kind, input logic [SPRITE_W-1:0] spr,
                               input logic [XPOS_W-1:0] xpos,
                               input logic [ROW_BITS_W-1:0] bits,
                               input logic [ROW_WIDTH_W-1:0] w,
                               input logic [COLOUR_W-1:0] colour,
                               input logic [MASK_W-1:0] mask);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {6'd0, mask, colour, w, bits, xpos, spr};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      @(negedge clock);
      sent_total++;
   endtask

   task automatic send_row(input logic [SPRITE_W-1:0] spr, input logic [XPOS_W-1:0] xpos,
                           input logic [ROW_BITS_W-1:0] bits,
                           input logic [ROW_WIDTH_W-1:0] w,
                           input logic [COLOUR_W-1:0] colour, input logic [MASK_W-1:0] mask);
      send_request(KIND_SPRITE_ROW, spr, xpos, bits, w, colour, mask);
   endtask

   // clears and reads carry junk in the unused fields
   task automatic send_cmd(input req_kind_type kind, input logic [SPRITE_W-1:0] spr);
      send_request(kind, spr, XPOS_W'($urandom), $urandom, ROW_WIDTH_W'($urandom),
                   COLOUR_W'($urandom), MASK_W'($urandom));
   endtask

   // mostly in-range widths, some zero and some over the clamp
   function automatic logic [ROW_WIDTH_W-1:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 12) return ROW_WIDTH_W'($urandom_range(33, 63));
      if (r < 30) return ROW_WIDTH_W'(32);
      return ROW_WIDTH_W'($urandom_range(1, 32));
   endfunction

   // dense rows make overlaps likely, sparse ones test gaps
   function automatic logic [ROW_BITS_W-1:0] pick_bits();
      int r;
      r = $urandom_range(9);
      if (r < 2) return '1;
      if (r < 4) return $urandom | $urandom;
      return $urandom;
   endfunction

   // a well-formed scanline: optional frame start, clear, rows in non-decreasing sprite order, then one or two reads
   task automatic random_line();
      int spr;
      int n_rows;
      int xi;
      if ($urandom_range(3) == 0)
         send_cmd(KIND_FRAME_START, SPRITE_W'($urandom));
      send_cmd(KIND_LINE_START, SPRITE_W'($urandom));
      spr = $urandom_range(0, 3);
      n_rows = $urandom_range(2, 5);
      for (int r = 0; r < n_rows && spr < SPRITE_NUM; r++) begin
         // sometimes repeat a sprite on the same line
         xi = $urandom_range(0, 370) - 40;
         send_row(SPRITE_W'(spr), XPOS_W'(xi), pick_bits(), pick_width(),
                  COLOUR_W'($urandom), MASK_W'($urandom));
         spr += $urandom_range(0, 4);
      end
      repeat ($urandom_range(1, 2))
         send_cmd(KIND_READ, SPRITE_W'($urandom));
   endtask

   // anything the fields allow, mostly off-screen positions
   task automatic random_noise();
      send_request(req_kind_type'($urandom_range(0, 3)), SPRITE_W'($urandom),
                   XPOS_W'($urandom), $urandom, ROW_WIDTH_W'($urandom),
                   COLOUR_W'($urandom), MASK_W'($urandom));
   endtask

   initial begin
      int target;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, no gaps
      // empty accumulator right after reset
      send_cmd(KIND_READ, 0);
      // full-width row claims 0..31, next one overlaps 16..31
      send_row(0, 16'd0, 32'hFFFF_FFFF, 6'd32, 24'hFF_FFFF, 8'h01);
      send_row(1, 16'd16, 32'hFFFF_FFFF, 6'd32, 24'h00_0001, 8'h02);
      send_cmd(KIND_READ, 0);
      send_cmd(KIND_READ, 1);
      // same sprite again on its own pixels: collides with itself
      send_row(0, 16'd0, 32'h0000_00FF, 6'd8, 24'h12_3456, 8'h80);
      // partly left of the screen
      send_row(2, 16'hFFFC, 32'h0000_00FF, 6'd8, 24'h65_4321, 8'h04);
      // partly right of the screen
      send_row(3, 16'd316, 32'h0000_00FF, 6'd8, 24'hAA_AAAA, 8'h08);
      // fully off-screen at both ends of the position range
      send_row(4, 16'h7FFF, 32'hFFFF_FFFF, 6'd32, 24'h0F_0F0F, 8'h10);
      send_row(5, 16'h8000, 32'hFFFF_FFFF, 6'd32, 24'hF0_F0F0, 8'h20);
      // width zero still stores the mask
      send_row(6, 16'd100, 32'hFFFF_FFFF, 6'd0, 24'h33_3333, 8'h40);
      // width above the clamp, only end bits opaque
      send_row(7, 16'd200, 32'h8000_0001, 6'd63, 24'h55_5555, 8'h10);
      // bits above the width are ignored
      send_row(9, 16'd240, 32'hFFFF_FFF5, 6'd4, 24'h77_7777, 8'h00);
      // transparent row gives nothing
      send_row(10, 16'd250, 32'h0000_0000, 6'd32, 24'h99_9999, 8'hFF);
      send_row(11, 16'd60, 32'hFFFF_FFFF, 6'd33, 24'hCC_CCCC, 8'hC3);
      send_cmd(KIND_READ, 7);
      send_cmd(KIND_READ, 15);
      send_cmd(KIND_READ, 6);
      // frame start clears accumulators but keeps masks
      send_cmd(KIND_FRAME_START, 0);
      send_cmd(KIND_READ, 0);
      // fresh line, highest sprite first with no opaque bit in its width, then a lower one at the same x
      send_cmd(KIND_LINE_START, 0);
      send_row(15, 16'd100, 32'h8000_0000, 6'd1, 24'h00_0000, 8'hFF);
      send_row(8, 16'd100, 32'h0000_0001, 6'd1, 24'hAB_CDEF, 8'h55);
      send_cmd(KIND_READ, 15);
      send_cmd(KIND_READ, 8);

      // random part in four idle/stall mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 77; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 77; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         target = sent_total + 18;
         while (sent_total < target) begin
            if ($urandom_range(99) < 80) random_line();
            else random_noise();
         end
      end
      req_tvalid <= 1'b0;

      // drain, then let a trailing line start walk finish
      while (owed_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests over four idle/stall mixes", sent_total);
      $display("checked %0d pixel writes and %0d collision reports, %0d mismatches",
               pixel_total, report_total, mismatch_total);
      if (mismatch_total == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
